[hw/rtl/master_volume_fader_attenuator_defines.svh]
// assertion macros used by the checker file
// no dependencies; each macro expects a clk and rst in scope
`ifndef MASTER_VOLUME_FADER_ATTENUATOR_DEFINES_SVH
`define MASTER_VOLUME_FADER_ATTENUATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MVFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MVFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mvfa_pkg.sv]
// shared types and constants of the master volume fader / attenuator
// no dependencies
package mvfa_pkg;

  typedef enum logic [2:0] {
    CMD_SET_VOLUME = 3'd0,
    CMD_FADE_OUT   = 3'd1,
    CMD_FADE_IN    = 3'd2,
    CMD_TICK       = 3'd3,
    CMD_ATTENUATE  = 3'd4
  } cmd_t;

  // signed two-bit fade direction codes
  localparam logic [1:0] DIR_IDLE = 2'b00;
  localparam logic [1:0] DIR_IN   = 2'b01;
  localparam logic [1:0] DIR_OUT  = 2'b11;

  localparam logic [3:0] VOL_MAX = 4'd15;
  localparam logic [3:0] VOL_MIN = 4'd0;

  // psg / scc volume registers
  localparam logic [7:0] PSG_VOL_FIRST = 8'hB8;
  localparam logic [7:0] PSG_VOL_LAST  = 8'hBA;
  localparam logic [7:0] SCC_VOL_FIRST = 8'hAA;
  localparam logic [7:0] SCC_VOL_LAST  = 8'hAE;
  // opll instrument / volume registers
  localparam logic [7:0] OPLL_VOL_FIRST  = 8'hF0;
  localparam logic [7:0] OPLL_VOL_LAST   = 8'hF8;
  localparam logic [7:0] OPLL_RHY_FIRST  = 8'hF7;

  typedef struct packed {
    logic [3:0] volume;
    logic [1:0] direction;
    logic       active;
    logic       mute;
    logic       apply;
  } fade_status_t;

endpackage

[hw/rtl/mvfa_atten.sv]
// register value attenuation for psg/scc and opll volume addresses
// depends on mvfa_pkg
module mvfa_atten
  import mvfa_pkg::*;
(
  input  logic [7:0] address,
  input  logic [7:0] value,
  input  logic       rhythm_mode,
  input  logic [3:0] volume,
  output logic [7:0] result
);

  logic [3:0] att;
  logic       is_psg;
  logic       is_opll;
  logic [3:0] lo_raised;
  logic [3:0] hi_raised;
  logic [4:0] lo_sum;
  logic [4:0] hi_sum;

  always_comb begin
    att    = VOL_MAX - volume;
    is_psg = ((address >= PSG_VOL_FIRST) && (address <= PSG_VOL_LAST)) ||
             ((address >= SCC_VOL_FIRST) && (address <= SCC_VOL_LAST));
    is_opll = (address >= OPLL_VOL_FIRST) && (address <= OPLL_VOL_LAST);

    // saturating nibble raise
    lo_sum    = {1'b0, value[3:0]} + {1'b0, att};
    hi_sum    = {1'b0, value[7:4]} + {1'b0, att};
    lo_raised = lo_sum[4] ? VOL_MAX : lo_sum[3:0];
    hi_raised = hi_sum[4] ? VOL_MAX : hi_sum[3:0];

    if (is_psg) begin
      if (value[7:4] != 4'd0) begin
        result = value; // hardware envelope passes
      end else if (value[3:0] > att) begin
        result = {4'd0, value[3:0] - att};
      end else begin
        result = 8'd0;
      end
    end else if (is_opll) begin
      if (rhythm_mode && (address >= OPLL_RHY_FIRST)) begin
        result = {hi_raised, lo_raised};
      end else begin
        result = {value[7:4], lo_raised};
      end
    end else begin
      result = value;
    end
  end

endmodule

[hw/rtl/mvfa_fader.sv]
// master volume and fade state, command decode and tick stepping
// depends on mvfa_pkg
module mvfa_fader
  import mvfa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  cmd_t         cmd,
  input  logic [7:0]   value,
  output logic [3:0]   volume,
  output fade_status_t status
);

  logic [3:0] volume_next;
  logic [7:0] period;
  logic [7:0] period_next;
  logic [7:0] countdown;
  logic [7:0] countdown_next;
  logic [1:0] dir;
  logic [1:0] dir_next;
  logic       stepped;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume    <= VOL_MAX;
      period    <= 8'd0;
      countdown <= 8'd0;
      dir       <= DIR_IDLE;
    end else if (fire) begin
      volume    <= volume_next;
      period    <= period_next;
      countdown <= countdown_next;
      dir       <= dir_next;
    end
  end

  always_comb begin
    volume_next    = volume;
    period_next    = period;
    countdown_next = countdown;
    dir_next       = dir;
    stepped        = 1'b0;
    status         = '0;

    unique case (cmd)
      CMD_SET_VOLUME: begin
        if (value[7:4] == 4'd0) begin
          volume_next = value[3:0];
        end
      end
      CMD_FADE_OUT: begin
        period_next    = value;
        countdown_next = value;
        dir_next       = DIR_OUT;
      end
      CMD_FADE_IN: begin
        period_next    = value;
        countdown_next = value;
        dir_next       = DIR_IN;
      end
      CMD_TICK: begin
        if (dir != DIR_IDLE) begin
          if (countdown != 8'd0) begin
            countdown_next = countdown - 8'd1;
            stepped        = 1'b1;
          end else begin
            countdown_next = period;
            if (((dir == DIR_IN) && (volume == VOL_MAX)) ||
                ((dir == DIR_OUT) && (volume == VOL_MIN))) begin
              dir_next = DIR_IDLE;
            end else begin
              volume_next = (dir == DIR_IN) ? volume + 4'd1 : volume - 4'd1;
              stepped     = 1'b1;
            end
          end
        end
        status.active = stepped;
        if (volume_next != VOL_MAX) begin
          if (!stepped && (volume_next == VOL_MIN)) begin
            status.mute = 1'b1;
          end else begin
            status.apply = 1'b1;
          end
        end
      end
      CMD_ATTENUATE: begin
      end
      default: begin
      end
    endcase

    status.volume    = volume_next;
    status.direction = dir_next;
  end

endmodule

[hw/rtl/master_volume_fader_attenuator.sv]
// top level of the master volume fader / attenuator
// depends on mvfa_pkg, mvfa_fader, mvfa_atten
//
// channel  signals                                         dir
// -------  ----------------------------------------------  ---
// in       in_valid, in_stall, command, address, value,    in
//          rhythm_mode
// out      out_valid, out_stall, out_value, master_volume, out
//          fade_direction, fade_active, mute_all,
//          apply_needed
//
// one word per cycle sustained while out_stall is low
// the path is input register -> fader update / attenuator -> result register
// state (volume, period, countdown, direction) updates as a word leaves the
// input register, so the next word already sees it
// synchronous active-high reset: volume 15, fader idle, both stages empty
// out_stall holds the result register; the input register keeps taking a
// word while the result register drains, and stalls only when both are full
module master_volume_fader_attenuator
  import mvfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] command,
  input  logic [7:0] address,
  input  logic [7:0] value,
  input  logic       rhythm_mode,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_value,
  output logic [3:0] master_volume,
  output logic [1:0] fade_direction,
  output logic       fade_active,
  output logic       mute_all,
  output logic       apply_needed
);

  // input register
  logic       hold_valid;
  logic [2:0] hold_command;
  logic [7:0] hold_address;
  logic [7:0] hold_value;
  logic       hold_rhythm;

  // handshake between the two stages
  logic         advance;
  logic         in_take;
  cmd_t         cmd;
  logic [3:0]   volume;
  fade_status_t status;
  logic [7:0]   atten_value;

  // a word moves on when the result register is empty or being drained
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;
  assign in_take  = in_valid && !in_stall;
  assign cmd      = cmd_t'(hold_command);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_command <= command;
      hold_address <= address;
      hold_value   <= value;
      hold_rhythm  <= rhythm_mode;
    end
  end

  // state and command decode; state moves only when the word advances
  mvfa_fader u_fader (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .cmd    (cmd),
    .value  (hold_value),
    .volume (volume),
    .status (status)
  );

  // attenuation against the volume before this word (attenuate leaves it)
  mvfa_atten u_atten (
    .address     (hold_address),
    .value       (hold_value),
    .rhythm_mode (hold_rhythm),
    .volume      (volume),
    .result      (atten_value)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value      <= (cmd == CMD_ATTENUATE) ? atten_value : 8'd0;
      master_volume  <= status.volume;
      fade_direction <= status.direction;
      fade_active    <= status.active;
      mute_all       <= status.mute;
      apply_needed   <= status.apply;
    end
  end

endmodule

[hw/rtl/mvfa_checker.sv]
// port-level checker for the master volume fader / attenuator, with bind
// depends on master_volume_fader_attenuator_defines.svh and mvfa_pkg
`include "master_volume_fader_attenuator_defines.svh"

module mvfa_checker
  import mvfa_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] command,
  input logic [7:0] address,
  input logic [7:0] value,
  input logic       rhythm_mode,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_value,
  input logic [3:0] master_volume,
  input logic [1:0] fade_direction,
  input logic       fade_active,
  input logic       mute_all,
  input logic       apply_needed
);

  logic        out_hold;
  logic        in_hold;
  logic [16:0] out_word;
  logic [19:0] in_word;
  logic        mute_ok;
  logic        fade_run;

  assign out_hold = out_valid && out_stall;
  assign in_hold  = in_valid && in_stall;
  assign out_word = {out_value, master_volume, fade_direction, fade_active, mute_all,
                     apply_needed};
  assign in_word  = {command, address, value, rhythm_mode};
  assign mute_ok  = (master_volume == VOL_MIN) && !fade_active;
  assign fade_run = out_valid && fade_active;

  // a stalled result stays put
  `MVFA_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_word), "stalled result moved")

  // a stalled input word stays put
  `MVFA_ASSERT_NEXT(a_in_hold, in_hold, in_valid && $stable(in_word), "stalled input moved")

  // mute and apply are exclusive outcomes of a tick
  `MVFA_ASSERT_NOW(a_mute_apply, out_valid, !(mute_all && apply_needed), "mute with apply")

  // mute means full attenuation with no fade step
  `MVFA_ASSERT_NOW(a_mute_vol, out_valid && mute_all, mute_ok, "mute without silence")

  // an active fade has a direction
  `MVFA_ASSERT_NOW(a_active_dir, fade_run, fade_direction != DIR_IDLE, "fade without direction")

endmodule

bind master_volume_fader_attenuator mvfa_checker u_mvfa_checker (.*);
